// ===== src/fe_shape_function_eval_unit_macros.svh =====
// Assertion helpers for the shape function evaluator
`ifndef FE_SHAPE_FUNCTION_EVAL_UNIT_MACROS_SVH
`define FE_SHAPE_FUNCTION_EVAL_UNIT_MACROS_SVH

// check a property on every edge outside reset
`define FSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property on every edge, reset included
`define FSE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/fse_pkg.sv =====
// ----------------------------------------------------------------------------
// fse_pkg
// Types, constants and helpers of the shape function evaluator.
// ----------------------------------------------------------------------------
package fse_pkg;

  localparam int FRAC_BITS = 14;
  localparam int COORD_W   = 16;
  localparam int OUT_W     = 20;
  localparam int NODE_W    = 4;
  localparam int TYPE_W    = 3;
  // wide enough for every exact intermediate (products up to 2^38)
  localparam int ACC_W     = 56;

  typedef enum logic [TYPE_W-1:0] {
    ET_TRI3    = 3'd0,
    ET_QUAD4   = 3'd1,
    ET_TRI6    = 3'd2,
    ET_HEXA8   = 3'd3,
    ET_TETRA4  = 3'd4,
    ET_TETRA10 = 3'd5
  } elem_t;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [OUT_W-1:0] res_t;

  // node count of an element type, zero for unused codes
  function automatic logic [NODE_W-1:0] node_count(input logic [TYPE_W-1:0] et);
    logic [NODE_W-1:0] n;
    case (et)
      ET_TRI3:    n = 4'd3;
      ET_QUAD4:   n = 4'd4;
      ET_TRI6:    n = 4'd6;
      ET_HEXA8:   n = 4'd8;
      ET_TETRA4:  n = 4'd4;
      ET_TETRA10: n = 4'd10;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  // add half then floor (arithmetic shift floors)
  function automatic acc_t rnd(input acc_t x, input int s);
    acc_t y;
    y = x + (acc_t'(1) <<< (s - 1));
    return y >>> s;
  endfunction

  function automatic res_t sat20(input acc_t x);
    res_t r;
    if (x > acc_t'((1 <<< (OUT_W - 1)) - 1))      r = {1'b0, {(OUT_W-1){1'b1}}};
    else if (x < -acc_t'(1 <<< (OUT_W - 1)))      r = {1'b1, {(OUT_W-1){1'b0}}};
    else                                          r = x[OUT_W-1:0];
    return r;
  endfunction

endpackage

// ===== src/fe_shape_function_eval_unit.sv =====
// ----------------------------------------------------------------------------
// fe_shape_function_eval_unit
// Lagrange shape functions and derivatives at a reference point.
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// s_axis    in   s_axis_tvalid/tready xi, eta, zeta
// m_axis    out  m_axis_tvalid/tready node, value, d_xi, d_eta, d_zeta, last
// cfg       in   cfg_we               element_type
//
// A point yields N node items (3..10; none for unused codes), one per cycle unless m_axis stalls.
// The node sequencer feeds a four stage pipeline (operands, products,
// second product, round/saturate); one item per cycle enters it unless m_axis stalls.
// rst clears the register and all valid bits. A stall on m_axis freezes
// the whole pipeline; no item is lost or repeated.
`include "fe_shape_function_eval_unit_macros.svh"

module fe_shape_function_eval_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] xi_coord, [31:16] eta_coord, [47:32] zeta_coord
  input  logic [47:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [3:0] node_index, [23:4] shape_value, [43:24] d_xi, [63:44] d_eta,
  // [83:64] d_zeta, zero fill to 88
  output logic [87:0]  m_axis_tdata,
  // [0] last_node
  output logic         m_axis_tlast
);

  localparam int F   = fse_pkg::FRAC_BITS;
  localparam int CW  = fse_pkg::COORD_W;
  localparam int NW  = fse_pkg::NODE_W;

  logic [fse_pkg::TYPE_W-1:0] element_type;
  always_ff @(posedge clk) begin
    if (rst) element_type <= '0;
    else if (cfg_we) element_type <= cfg_wdata;
  end

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;

  // ---- node sequencer
  logic              busy;
  logic [NW-1:0]     node, cnt;
  logic [fse_pkg::TYPE_W-1:0] et_cur;
  logic signed [CW-1:0] px, py, pz;
  logic              s0_fire;
  assign cnt = fse_pkg::node_count(et_cur);
  // next point may enter while the last node of the current one issues
  assign s_axis_tready = !busy || (s0_fire && node == cnt - 4'd1);
  assign s0_fire = busy && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      node <= '0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      busy <= fse_pkg::node_count(element_type) != '0;
      node <= '0;
    end else if (s0_fire) begin
      if (node == cnt - 4'd1) busy <= 1'b0;
      node <= node + 4'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      et_cur <= element_type;
      px <= s_axis_tdata[15:0];
      py <= s_axis_tdata[31:16];
      pz <= s_axis_tdata[47:32];
    end
  end

  // ---- stage 1: operands per node. Each output = rnd(a*b*c, sh) or a clamped lin term
  // value: (a*b) rounded to F bits if use_r1, times c, then rounded by sh (0 = none)
  typedef struct packed {
    logic [NW-1:0] node;
    logic          last;
  } tag_t;
  typedef logic signed [19:0] op_t;   // operand up to ~2^18
  typedef struct packed {
    op_t  a, b, c;     // product a*b*c (c = one for two-term forms)
    logic use_r1;      // round a*b to F bits before times c
    logic [5:0] sh;    // final shift, 0 = none
  } term_t;

  tag_t  t1, t2, t3;
  logic  v1, v2, v3;
  term_t tm1 [4];
  term_t tm2 [4];
  fse_pkg::acc_t p2 [4];
  fse_pkg::acc_t p3 [4];
  term_t tm3 [4];

  localparam op_t ONE = op_t'(1 <<< F);

  // linear terms can exceed the output range; clamp here
  function automatic term_t lin(input fse_pkg::acc_t x);
    term_t t;
    t.a = fse_pkg::sat20(x); t.b = 20'sd1; t.c = 20'sd1; t.use_r1 = 1'b0; t.sh = '0;
    return t;
  endfunction
  function automatic term_t prod(input op_t a, input op_t b, input int s);
    term_t t;
    t.a = a; t.b = b; t.c = 20'sd1; t.use_r1 = 1'b0; t.sh = 6'(s);
    return t;
  endfunction

  term_t tn [4];
  always_comb begin
    op_t x, y, z, lam2, lam3, sx, sy, sz, a, b, c;
    fse_pkg::acc_t ex, ey, ez, eo;
    x = op_t'(px); y = op_t'(py); z = op_t'(pz);
    ex = fse_pkg::acc_t'(px); ey = fse_pkg::acc_t'(py); ez = fse_pkg::acc_t'(pz);
    eo = fse_pkg::acc_t'(ONE);
    lam2 = ONE - x - y;
    lam3 = ONE - x - y - z;
    sx = (node[1:0] == 2'd1 || node[1:0] == 2'd2) ? 20'sd1 : -20'sd1;
    sy = node[1] ? 20'sd1 : -20'sd1;
    sz = node[2] ? 20'sd1 : -20'sd1;
    a = ONE + sx * x; b = ONE + sy * y; c = ONE + sz * z;
    for (int k = 0; k < 4; k++) tn[k] = lin('0);
    case (et_cur)
      fse_pkg::ET_TRI3: begin
        case (node)
          4'd0: begin tn[0] = lin(eo - ex - ey); tn[1] = lin(-eo); tn[2] = lin(-eo); end
          4'd1: begin tn[0] = lin(ex); tn[1] = lin(eo); end
          default: begin tn[0] = lin(ey); tn[2] = lin(eo); end
        endcase
      end
      fse_pkg::ET_QUAD4: begin
        tn[0] = prod(a, b, F + 2);
        tn[1] = prod(sx, b, 2);
        tn[2] = prod(sy, a, 2);
      end
      fse_pkg::ET_HEXA8: begin
        tn[0] = prod(a, b, F + 3); tn[0].c = c; tn[0].use_r1 = 1'b1;
        tn[1] = prod(sx * b, c, F + 3);
        tn[2] = prod(sy * a, c, F + 3);
        tn[3] = prod(sz * a, b, F + 3);
      end
      fse_pkg::ET_TETRA4: begin
        case (node)
          4'd0: begin
            tn[0] = lin(eo - ex - ey - ez);
            tn[1] = lin(-eo); tn[2] = lin(-eo); tn[3] = lin(-eo);
          end
          4'd1: begin tn[0] = lin(ex); tn[1] = lin(eo); end
          4'd2: begin tn[0] = lin(ey); tn[2] = lin(eo); end
          default: begin tn[0] = lin(ez); tn[3] = lin(eo); end
        endcase
      end
      fse_pkg::ET_TRI6: begin
        case (node)
          4'd0: begin
            tn[0] = prod(lam2, op_t'(2 * lam2 - ONE), F);
            tn[1] = lin(4 * ex + 4 * ey - 3 * eo); tn[2] = tn[1];
          end
          4'd1: begin tn[0] = prod(x, op_t'(2 * x - ONE), F); tn[1] = lin(4 * ex - eo); end
          4'd2: begin tn[0] = prod(y, op_t'(2 * y - ONE), F); tn[2] = lin(4 * ey - eo); end
          4'd3: begin
            tn[0] = prod(lam2, x, F - 2);
            tn[1] = lin(4 * eo - 8 * ex - 4 * ey); tn[2] = lin(-4 * ex);
          end
          4'd4: begin tn[0] = prod(y, x, F - 2); tn[1] = lin(4 * ey); tn[2] = lin(4 * ex); end
          default: begin
            tn[0] = prod(lam2, y, F - 2);
            tn[1] = lin(-4 * ey); tn[2] = lin(4 * eo - 4 * ex - 8 * ey);
          end
        endcase
      end
      default: begin
        case (node)
          4'd0: begin
            tn[0] = prod(lam3, op_t'(2 * lam3 - ONE), F);
            tn[1] = lin(4 * ex + 4 * ey + 4 * ez - 3 * eo); tn[2] = tn[1]; tn[3] = tn[1];
          end
          4'd1: begin tn[0] = prod(x, op_t'(2 * x - ONE), F); tn[1] = lin(4 * ex - eo); end
          4'd2: begin tn[0] = prod(y, op_t'(2 * y - ONE), F); tn[2] = lin(4 * ey - eo); end
          4'd3: begin tn[0] = prod(z, op_t'(2 * z - ONE), F); tn[3] = lin(4 * ez - eo); end
          4'd4: begin
            tn[0] = prod(x, lam3, F - 2);
            tn[1] = lin(4 * eo - 8 * ex - 4 * ez - 4 * ey);
            tn[2] = lin(-4 * ex); tn[3] = lin(-4 * ex);
          end
          4'd5: begin tn[0] = prod(x, y, F - 2); tn[1] = lin(4 * ey); tn[2] = lin(4 * ex); end
          4'd6: begin
            tn[0] = prod(y, lam3, F - 2);
            tn[1] = lin(-4 * ey); tn[2] = lin(4 * eo - 4 * ex - 4 * ez - 8 * ey);
            tn[3] = lin(-4 * ey);
          end
          4'd7: begin
            tn[0] = prod(z, lam3, F - 2);
            tn[1] = lin(-4 * ez); tn[2] = lin(-4 * ez);
            tn[3] = lin(4 * eo - 4 * ex - 8 * ez - 4 * ey);
          end
          4'd8: begin tn[0] = prod(y, z, F - 2); tn[2] = lin(4 * ez); tn[3] = lin(4 * ey); end
          default: begin tn[0] = prod(x, z, F - 2); tn[1] = lin(4 * ez); tn[3] = lin(4 * ex); end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v1 <= s0_fire; v2 <= v1; v3 <= v2; m_axis_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1.node <= node;
      t1.last <= node == cnt - 4'd1;
      tm1 <= tn;
      t2 <= t1; t3 <= t2;
      for (int k = 0; k < 4; k++) begin
        // stage 2: first product
        p2[k]  <= fse_pkg::acc_t'(tm1[k].a) * fse_pkg::acc_t'(tm1[k].b);
        tm2[k] <= tm1[k];
        // stage 3: second product only on the rounded hexahedron value
        p3[k]  <= tm2[k].use_r1
                  ? fse_pkg::acc_t'(op_t'(fse_pkg::rnd(p2[k], F)))
                    * fse_pkg::acc_t'(tm2[k].c)
                  : p2[k];
        tm3[k] <= tm2[k];
      end
    end
  end

  // stage 4: final rounding and saturation
  fse_pkg::res_t r4 [4];
  always_comb begin
    for (int k = 0; k < 4; k++)
      r4[k] = fse_pkg::sat20(tm3[k].sh == '0 ? p3[k] : fse_pkg::rnd(p3[k], int'(tm3[k].sh)));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {4'd0, r4[3], r4[2], r4[1], r4[0], t3.node};
      m_axis_tlast <= t3.last;
    end
  end

  `FSE_ASSERT(a_no_accept_busy, (busy && s_axis_tready) |-> (s0_fire && node == cnt - 4'd1), "accept while busy")
  `FSE_ASSERT(a_hold_stall, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "output changed under stall")
  `FSE_ASSERT(a_node_range, busy |-> (node < cnt), "node beyond count")
  `FSE_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_axis_tvalid && !busy, "not idle after reset")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shape function evaluator: directed table of
// points over every element type, then random points with random bursts
// and output stalls, all compared against an in-bench model.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [3:0]        node;
    logic signed [19:0] val;
    logic signed [19:0] dxi;
    logic signed [19:0] deta;
    logic signed [19:0] dzeta;
    logic              last;
  } node_res_t;

  typedef struct {
    logic [2:0]  et;       // element type in force for this row
    logic [15:0] xi, eta, zeta;
    bit          has_exp;  // node 0 result typed in
    node_res_t   exp0;
  } pt_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tlast;

  always #1 clk = ~clk;

  fe_shape_function_eval_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  node_res_t   node_q[$];
  logic [2:0]  elem_sel;
  int          errors = 0;
  int          points_sent = 0;
  int          nodes_seen = 0;
  longint      cycles = 0;
  bit          stall_on = 1'b1;

  localparam longint ONE = 64'sd1 << fse_pkg::FRAC_BITS;

  function automatic longint round_up(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [19:0] clamp20(longint x);
    if (x > 524287) return 20'sd524287;
    if (x < -524288) return -20'sd524288;
    return x[19:0];
  endfunction

  // expected node results for one point under the current element type
  task automatic predict_nodes(logic [15:0] xr, logic [15:0] yr, logic [15:0] zr);
    longint x, y, z, lam, a, b, c;
    longint v[10], dx[10], dy[10], dz[10];
    int n, sx, sy, sz;
    node_res_t r;
    x = longint'($signed(xr));
    y = longint'($signed(yr));
    z = longint'($signed(zr));
    for (int i = 0; i < 10; i++) begin
      v[i] = 0; dx[i] = 0; dy[i] = 0; dz[i] = 0;
    end
    n = 0;
    case (elem_sel)
      fse_pkg::ET_TRI3: begin
        n = 3;
        v[0] = ONE - x - y; dx[0] = -ONE; dy[0] = -ONE;
        v[1] = x; dx[1] = ONE;
        v[2] = y; dy[2] = ONE;
      end
      fse_pkg::ET_QUAD4: begin
        n = 4;
        for (int i = 0; i < 4; i++) begin
          sx = (i == 1 || i == 2) ? 1 : -1;
          sy = (i >= 2) ? 1 : -1;
          a = ONE + sx * x;
          b = ONE + sy * y;
          v[i] = round_up(a * b, fse_pkg::FRAC_BITS + 2);
          dx[i] = round_up(sx * b, 2);
          dy[i] = round_up(sy * a, 2);
        end
      end
      fse_pkg::ET_TRI6: begin
        n = 6;
        lam = ONE - x - y;
        v[0] = round_up(lam * (2 * lam - ONE), fse_pkg::FRAC_BITS);
        v[1] = round_up(x * (2 * x - ONE), fse_pkg::FRAC_BITS);
        v[2] = round_up(y * (2 * y - ONE), fse_pkg::FRAC_BITS);
        v[3] = round_up(lam * x, fse_pkg::FRAC_BITS - 2);
        v[4] = round_up(y * x, fse_pkg::FRAC_BITS - 2);
        v[5] = round_up(lam * y, fse_pkg::FRAC_BITS - 2);
        dx[0] = 4 * x + 4 * y - 3 * ONE; dy[0] = dx[0];
        dx[1] = 4 * x - ONE;
        dy[2] = 4 * y - ONE;
        dx[3] = 4 * ONE - 8 * x - 4 * y; dy[3] = -4 * x;
        dx[4] = 4 * y; dy[4] = 4 * x;
        dx[5] = -4 * y; dy[5] = 4 * ONE - 4 * x - 8 * y;
      end
      fse_pkg::ET_HEXA8: begin
        n = 8;
        for (int i = 0; i < 8; i++) begin
          sx = ((i & 3) == 1 || (i & 3) == 2) ? 1 : -1;
          sy = ((i & 3) >= 2) ? 1 : -1;
          sz = (i >= 4) ? 1 : -1;
          a = ONE + sx * x;
          b = ONE + sy * y;
          c = ONE + sz * z;
          v[i] = round_up(round_up(a * b, fse_pkg::FRAC_BITS) * c, fse_pkg::FRAC_BITS + 3);
          dx[i] = round_up(sx * (b * c), fse_pkg::FRAC_BITS + 3);
          dy[i] = round_up(sy * (a * c), fse_pkg::FRAC_BITS + 3);
          dz[i] = round_up(sz * (a * b), fse_pkg::FRAC_BITS + 3);
        end
      end
      fse_pkg::ET_TETRA4: begin
        n = 4;
        v[0] = ONE - x - y - z; dx[0] = -ONE; dy[0] = -ONE; dz[0] = -ONE;
        v[1] = x; dx[1] = ONE;
        v[2] = y; dy[2] = ONE;
        v[3] = z; dz[3] = ONE;
      end
      fse_pkg::ET_TETRA10: begin
        n = 10;
        lam = ONE - x - y - z;
        v[0] = round_up(lam * (2 * lam - ONE), fse_pkg::FRAC_BITS);
        v[1] = round_up(x * (2 * x - ONE), fse_pkg::FRAC_BITS);
        v[2] = round_up(y * (2 * y - ONE), fse_pkg::FRAC_BITS);
        v[3] = round_up(z * (2 * z - ONE), fse_pkg::FRAC_BITS);
        v[4] = round_up(x * lam, fse_pkg::FRAC_BITS - 2);
        v[5] = round_up(x * y, fse_pkg::FRAC_BITS - 2);
        v[6] = round_up(y * lam, fse_pkg::FRAC_BITS - 2);
        v[7] = round_up(z * lam, fse_pkg::FRAC_BITS - 2);
        v[8] = round_up(y * z, fse_pkg::FRAC_BITS - 2);
        v[9] = round_up(x * z, fse_pkg::FRAC_BITS - 2);
        dx[0] = 4 * x + 4 * y + 4 * z - 3 * ONE; dy[0] = dx[0]; dz[0] = dx[0];
        dx[1] = 4 * x - ONE;
        dy[2] = 4 * y - ONE;
        dz[3] = 4 * z - ONE;
        dx[4] = 4 * ONE - 8 * x - 4 * z - 4 * y; dy[4] = -4 * x; dz[4] = -4 * x;
        dx[5] = 4 * y; dy[5] = 4 * x;
        dx[6] = -4 * y; dy[6] = 4 * ONE - 4 * x - 4 * z - 8 * y; dz[6] = -4 * y;
        dx[7] = -4 * z; dy[7] = -4 * z; dz[7] = 4 * ONE - 4 * x - 8 * z - 4 * y;
        dy[8] = 4 * z; dz[8] = 4 * y;
        dx[9] = 4 * z; dz[9] = 4 * x;
      end
      default: n = 0;  // unused codes drop the point
    endcase
    for (int i = 0; i < n; i++) begin
      r.node  = i[3:0];
      r.val   = clamp20(v[i]);
      r.dxi   = clamp20(dx[i]);
      r.deta  = clamp20(dy[i]);
      r.dzeta = clamp20(dz[i]);
      r.last  = (i == n - 1);
      node_q.push_back(r);
    end
  endtask

  // output side: stall pattern plus checking
  always @(posedge clk) begin
    node_res_t got, want;
    cycles <= cycles + 1;
    if (!rst) begin
      m_axis_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
      if (m_axis_tvalid && m_axis_tready) begin
        got.node  = m_axis_tdata[3:0];
        got.val   = m_axis_tdata[23:4];
        got.dxi   = m_axis_tdata[43:24];
        got.deta  = m_axis_tdata[63:44];
        got.dzeta = m_axis_tdata[83:64];
        got.last  = m_axis_tlast;
        nodes_seen <= nodes_seen + 1;
        if (node_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, actual %p", $time, got);
        end else begin
          want = node_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch, expected %p actual %p", $time, want, got);
          end
        end
      end
    end
    if (cycles > 400000) begin
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic set_elem(logic [2:0] et);
    // wait for idle; unused codes may leave nothing to wait on, so pad
    while (node_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= et;
    @(posedge clk);
    cfg_we <= 1'b0;
    elem_sel = et;
  endtask

  // hand one point over; caller decides gaps
  task automatic send_point(logic [15:0] xr, logic [15:0] yr, logic [15:0] zr);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {zr, yr, xr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_nodes(xr, yr, zr);
    points_sent++;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 16384));
      2: return 16'(16'sh8000 + $urandom_range(0, 7));
      default: return 16'(16'sh7fff - $urandom_range(0, 7));
    endcase
  endfunction

  pt_row_t table_rows[$];

  initial begin
    pt_row_t row;
    node_res_t want0;
    int burst;
    logic [2:0] et_list[8] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};

    // directed: origin for each type, extremes, unused codes
    for (int t = 0; t < 8; t++) begin
      row = '{et: t[2:0], xi: 16'h0000, eta: 16'h0000, zeta: 16'h0000,
              has_exp: 1'b0, exp0: '0};
      table_rows.push_back(row);
      row.xi = 16'h7fff; row.eta = 16'h8000; row.zeta = 16'h7fff;
      table_rows.push_back(row);
      row.xi = 16'h8000; row.eta = 16'h7fff; row.zeta = 16'h8000;
      table_rows.push_back(row);
    end
    // tri3 at the origin after reset: N0 = 1, derivatives -1
    table_rows[0].has_exp = 1'b1;
    table_rows[0].exp0 = '{node: 4'd0, val: 20'sd16384, dxi: -20'sd16384,
                           deta: -20'sd16384, dzeta: 20'sd0, last: 1'b0};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    elem_sel = fse_pkg::ET_TRI3;
    m_axis_tready <= 1'b1;

    foreach (table_rows[k]) begin
      if (table_rows[k].et != elem_sel) begin
        s_axis_tvalid <= 1'b0;
        set_elem(table_rows[k].et);
      end
      if (table_rows[k].has_exp) begin
        send_point(table_rows[k].xi, table_rows[k].eta, table_rows[k].zeta);
        want0 = node_q[0];
        if (want0 !== table_rows[k].exp0) begin
          errors++;
          $display("%0t: table mismatch, expected %p actual %p", $time,
                   table_rows[k].exp0, want0);
        end
      end else begin
        send_point(table_rows[k].xi, table_rows[k].eta, table_rows[k].zeta);
      end
    end
    s_axis_tvalid <= 1'b0;

    // random: phases over every type, extremes included, in bursts
    for (int ph = 0; ph < 10; ph++) begin
      set_elem(ph < 8 ? et_list[ph] : 3'($urandom_range(0, 5)));
      stall_on = (ph % 3 != 2);
      for (int k = 0; k < 9; k++) begin
        burst = $urandom_range(0, 3);
        send_point(rand_coord(), rand_coord(), rand_coord());
        if (burst == 0 && stall_on) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
      s_axis_tvalid <= 1'b0;
    end

    while (node_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d points over all element types and unused codes, %0d node items",
             points_sent, nodes_seen);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== fe_shape_function_eval_unit.f =====
+incdir+src
src/fse_pkg.sv
src/fe_shape_function_eval_unit.sv
tb/tb.sv
